@@ sv/set_assoc_lru_cache_sim_assert.svh @@
`ifndef SET_ASSOC_LRU_CACHE_SIM_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_SIM_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define SACS_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("sacs check failed");

// antecedent implies consequent in the next cycle
`define SACS_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("sacs check failed");

`else

`define SACS_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define SACS_ASSERT_NEXT(lbl, ck, rs, ante, cons)

`endif

`endif

@@ sv/sacs_pkg.sv @@
package sacs_pkg;

  localparam int ADDR_W    = 64;
  localparam int TAG_W     = 32;
  localparam int STAMP_W   = 64;
  localparam int COUNT_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 5;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_PICK
  } state_t;

  localparam logic [1:0] ACT_MODIFY = 2'd2;
  localparam logic [1:0] ACT_INSTR  = 2'd3;

  localparam logic [1:0] OUT_HIT   = 2'd0;
  localparam logic [1:0] OUT_MISS  = 2'd1;
  localparam logic [1:0] OUT_EVICT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

  localparam logic [2:0] RST_SET_BITS   = 3'd4;
  localparam logic [4:0] RST_BLOCK_BITS = 5'd4;
  localparam logic [3:0] RST_WAYS       = 4'd1;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } line_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (v == {COUNT_W{1'b1}}) ? v : v + {{(COUNT_W-1){1'b0}}, 1'b1};
  endfunction

endpackage

@@ sv/set_assoc_lru_cache_sim.sv @@
// a request is accepted while idle and its set row is read; the tag compare is
// registered in ST_LOOK and the result register loads when ST_PICK commits
// a new load, store or modify request is taken only after the read-modify-write of
// the set row memory for the last one; instruction requests are taken while idle
// reset: synchronous; a clearing pass then zeroes the fill count of every set
// (2**MAX_SET_BITS sets, 64 by default), with in_stall held high
`include "set_assoc_lru_cache_sim_assert.svh"

module set_assoc_lru_cache_sim #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [sacs_pkg::ADDR_W-1:0]          address,
  input  logic [1:0]                           action,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           outcome,
  output logic                                 second_hit,
  output logic [sacs_pkg::COUNT_W-1:0]         hit_count,
  output logic [sacs_pkg::COUNT_W-1:0]         miss_count,
  output logic [sacs_pkg::COUNT_W-1:0]         evict_count,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [sacs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sacs_pkg::CFG_DAT_W-1:0]       cfg_data
);

  localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int FILL_W   = $clog2(MAX_WAYS + 1);
  localparam int TAG_W    = sacs_pkg::TAG_W;
  localparam int STAMP_W  = sacs_pkg::STAMP_W;
  localparam int COUNT_W  = sacs_pkg::COUNT_W;

  typedef struct packed {
    logic [FILL_W-1:0]                 fill;
    sacs_pkg::line_t [MAX_WAYS-1:0]    lines;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  sacs_pkg::state_t state, state_next;

  logic [2:0]          set_bits;
  logic [4:0]          block_bits;
  logic [3:0]          ways;
  logic [3:0]          eff_sb;
  logic [FILL_W-1:0]   eff_ways;

  logic [SET_W-1:0]    clear_addr;
  logic [SET_W-1:0]    set_q;
  logic [TAG_W-1:0]    tag_q;
  logic                modify_q;
  logic [STAMP_W-1:0]  now;

  logic                hit_q;
  logic [WAY_W-1:0]    hit_way_q;
  logic                fill_q;
  logic [COUNT_W-1:0]  age_q [MAX_WAYS];

  logic [COUNT_W-1:0]  hits_total, misses_total, evictions_total;

  logic                ram_we, ram_re;
  logic [SET_W-1:0]    ram_waddr, ram_raddr;
  logic [ROW_W-1:0]    ram_wdata, ram_rdata;
  row_t                rd_row, wr_row;

  logic                accept, commit;
  logic [sacs_pkg::ADDR_W-1:0] set_shift;
  logic [SET_W-1:0]    set_idx;
  logic [5:0]          tag_shamt;
  logic [TAG_W-1:0]    tag_in;

  logic                look_hit;
  logic [WAY_W-1:0]    look_hit_way;
  logic [STAMP_W-1:0]  age_diff [MAX_WAYS];
  logic [COUNT_W-1:0]  age_sat [MAX_WAYS];

  logic [WAY_W-1:0]    victim;
  logic [COUNT_W-1:0]  best_age;
  logic [WAY_W-1:0]    target;
  logic [COUNT_W-1:0]  hits_mid;

  // effective configuration
  always_comb begin
    if ({1'b0, set_bits} > 4'(MAX_SET_BITS)) begin
      eff_sb = 4'(MAX_SET_BITS);
    end else begin
      eff_sb = {1'b0, set_bits};
    end
    if (ways == 4'd0) begin
      eff_ways = FILL_W'(1);
    end else if (32'(ways) > 32'(MAX_WAYS)) begin
      eff_ways = FILL_W'(MAX_WAYS);
    end else begin
      eff_ways = FILL_W'(ways);
    end
  end

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits   <= sacs_pkg::RST_SET_BITS;
      block_bits <= sacs_pkg::RST_BLOCK_BITS;
      ways       <= sacs_pkg::RST_WAYS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sacs_pkg::CFG_SET_BITS:   set_bits   <= cfg_data[2:0];
        sacs_pkg::CFG_BLOCK_BITS: block_bits <= cfg_data;
        sacs_pkg::CFG_WAYS:       ways       <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // address decode
  assign set_shift = address >> block_bits;
  assign set_idx   = set_shift[SET_W-1:0] & ~({SET_W{1'b1}} << eff_sb);
  assign tag_shamt = 6'(eff_sb) + 6'(block_bits);
  assign tag_in    = TAG_W'(address >> tag_shamt);

  assign accept = in_valid && !in_stall;
  assign commit = (state == sacs_pkg::ST_PICK) && (!out_valid || !out_stall);

  assign rd_row = row_t'(ram_rdata);

  sacs_ram #(
    .WIDTH(ROW_W),
    .DEPTH(NUM_SETS),
    .AW   (SET_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sacs_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and memory control
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    ram_we     = 1'b0;
    ram_waddr  = set_q;
    ram_wdata  = ROW_W'(wr_row);
    ram_re     = 1'b0;
    ram_raddr  = set_idx;
    case (state)
      sacs_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clear_addr;
        ram_wdata = '0;
        if (clear_addr == SET_W'(NUM_SETS - 1)) begin
          state_next = sacs_pkg::ST_IDLE;
        end
      end
      sacs_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && action != sacs_pkg::ACT_INSTR) begin
          ram_re     = 1'b1;
          state_next = sacs_pkg::ST_LOOK;
        end
      end
      sacs_pkg::ST_LOOK: begin
        state_next = sacs_pkg::ST_PICK;
      end
      sacs_pkg::ST_PICK: begin
        if (commit) begin
          ram_we     = 1'b1;
          state_next = sacs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sacs_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
    end else if (state == sacs_pkg::ST_CLEAR) begin
      clear_addr <= clear_addr + SET_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      set_q    <= set_idx;
      tag_q    <= tag_in;
      modify_q <= (action == sacs_pkg::ACT_MODIFY);
    end
  end

  // tag compare and age of each way
  always_comb begin
    look_hit     = 1'b0;
    look_hit_way = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      age_diff[w] = now - rd_row.lines[w].stamp;
      age_sat[w]  = (age_diff[w][STAMP_W-1:COUNT_W] != '0) ? {COUNT_W{1'b1}}
                                                           : age_diff[w][COUNT_W-1:0];
      if (!look_hit && FILL_W'(w) < rd_row.fill && FILL_W'(w) < eff_ways &&
          rd_row.lines[w].tag == tag_q) begin
        look_hit     = 1'b1;
        look_hit_way = WAY_W'(w);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == sacs_pkg::ST_LOOK) begin
      hit_q     <= look_hit;
      hit_way_q <= look_hit_way;
      fill_q    <= !look_hit && (rd_row.fill < eff_ways);
      for (int w = 0; w < MAX_WAYS; w++) begin
        age_q[w] <= age_sat[w];
      end
    end
  end

  // oldest way, lowest index on ties
  always_comb begin
    victim   = '0;
    best_age = age_q[0];
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (FILL_W'(w) < eff_ways && age_q[w] > best_age) begin
        best_age = age_q[w];
        victim   = WAY_W'(w);
      end
    end
  end

  always_comb begin
    if (hit_q) begin
      target = hit_way_q;
    end else if (fill_q) begin
      target = WAY_W'(rd_row.fill);
    end else begin
      target = victim;
    end
    wr_row = rd_row;
    wr_row.lines[target].tag   = tag_q;
    wr_row.lines[target].stamp = now;
    if (fill_q) begin
      wr_row.fill = rd_row.fill + FILL_W'(1);
    end
  end

  assign hits_mid = hit_q ? sacs_pkg::sat_inc(hits_total) : hits_total;

  // running totals and item clock
  always_ff @(posedge clk) begin
    if (rst) begin
      hits_total      <= '0;
      misses_total    <= '0;
      evictions_total <= '0;
      now             <= '0;
    end else if (commit) begin
      hits_total <= modify_q ? sacs_pkg::sat_inc(hits_mid) : hits_mid;
      if (!hit_q) begin
        misses_total <= sacs_pkg::sat_inc(misses_total);
      end
      if (!hit_q && !fill_q) begin
        evictions_total <= sacs_pkg::sat_inc(evictions_total);
      end
      now <= now + STAMP_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      if (hit_q) begin
        outcome <= sacs_pkg::OUT_HIT;
      end else if (fill_q) begin
        outcome <= sacs_pkg::OUT_MISS;
      end else begin
        outcome <= sacs_pkg::OUT_EVICT;
      end
      second_hit <= modify_q;
    end
  end

  assign hit_count   = hits_total;
  assign miss_count  = misses_total;
  assign evict_count = evictions_total;

  `SACS_ASSERT_IMP(fill_in_range, clk, rst, state == sacs_pkg::ST_LOOK, rd_row.fill <= FILL_W'(MAX_WAYS))
  `SACS_ASSERT_IMP(evict_only_full, clk, rst, state == sacs_pkg::ST_PICK && !hit_q && !fill_q, rd_row.fill >= eff_ways)
  `SACS_ASSERT_NEXT(commit_shows, clk, rst, commit, out_valid && state == sacs_pkg::ST_IDLE)
  `SACS_ASSERT_NEXT(hit_counted, clk, rst, commit && hit_q, hit_count != '0 && outcome == sacs_pkg::OUT_HIT)

endmodule

@@ sv/sacs_ram.sv @@
module sacs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  parameter int AW    = 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ dv/set_assoc_lru_cache_sim_test.sv @@
module set_assoc_lru_cache_sim_test;

  localparam int ADDR_W    = sacs_pkg::ADDR_W;
  localparam int TAG_W     = sacs_pkg::TAG_W;
  localparam int COUNT_W   = sacs_pkg::COUNT_W;
  localparam int CFG_IDX_W = sacs_pkg::CFG_IDX_W;
  localparam int CFG_DAT_W = sacs_pkg::CFG_DAT_W;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_STORE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  localparam int SET_INDEX_MAX = 6;
  localparam int WAY_MAX       = 8;
  localparam int NUM_LINES     = (1 << SET_INDEX_MAX) * WAY_MAX;
  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 83;

  typedef struct packed {
    logic [1:0]         outcome;
    logic               second_hit;
    logic [COUNT_W-1:0] hits;
    logic [COUNT_W-1:0] misses;
    logic [COUNT_W-1:0] evictions;
  } access_result_t;

  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [CFG_DAT_W-1:0] reg_data;
    logic [ADDR_W-1:0]    addr;
    logic [1:0]           act;
    logic                 typed;
    access_result_t       want;
  } trace_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [ADDR_W-1:0]    address = '0;
  logic [1:0]           action = ACT_LOAD;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           outcome;
  logic                 second_hit;
  logic [COUNT_W-1:0]   hit_count;
  logic [COUNT_W-1:0]   miss_count;
  logic [COUNT_W-1:0]   evict_count;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = sacs_pkg::CFG_SET_BITS;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  // shadow copy of the cache
  logic               cached_valid [NUM_LINES];
  logic [TAG_W-1:0]   cached_tag   [NUM_LINES];
  logic [COUNT_W-1:0] cached_age   [NUM_LINES];
  logic [COUNT_W-1:0] hit_tally = '0;
  logic [COUNT_W-1:0] miss_tally = '0;
  logic [COUNT_W-1:0] evict_tally = '0;
  logic [2:0]         cur_set_bits = sacs_pkg::RST_SET_BITS;
  logic [4:0]         cur_block_bits = sacs_pkg::RST_BLOCK_BITS;
  logic [3:0]         cur_ways = sacs_pkg::RST_WAYS;

  access_result_t pending_results[$];
  trace_row_t     directed[$];
  int             errors = 0;
  bit             req_held = 1'b0;
  bit             burst_mode = 1'b0;
  bit             hold_go = 1'b0;
  bit             hold_done = 1'b0;

  set_assoc_lru_cache_sim #(
    .MAX_SET_BITS(SET_INDEX_MAX),
    .MAX_WAYS(WAY_MAX)
  ) dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int index_bits();
    return (cur_set_bits > SET_INDEX_MAX) ? SET_INDEX_MAX : int'(cur_set_bits);
  endfunction

  function automatic int way_count();
    if (cur_ways == 0) return 1;
    return (cur_ways > WAY_MAX) ? WAY_MAX : int'(cur_ways);
  endfunction

  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [1:0] touch_line(input logic [ADDR_W-1:0] addr);
    int sb, nw, base, w, hit_way, free_way, victim;
    logic [ADDR_W-1:0] shifted;
    logic [TAG_W-1:0] tag;
    logic [1:0] res;
    sb = index_bits();
    nw = way_count();
    shifted = addr >> (sb + cur_block_bits);
    tag = shifted[TAG_W-1:0];
    shifted = addr >> cur_block_bits;
    base = (int'(shifted[5:0]) & ((1 << sb) - 1)) * WAY_MAX;
    hit_way = -1;
    free_way = -1;
    victim = 0;
    for (w = 0; w < nw; w++) begin
      if (hit_way < 0 && cached_valid[base + w] && cached_tag[base + w] == tag) hit_way = w;
      if (free_way < 0 && !cached_valid[base + w]) free_way = w;
      if (w > 0 && cached_age[base + w] > cached_age[base + victim]) victim = w;
    end
    if (hit_way >= 0) begin
      cached_age[base + hit_way] = '0;
      if (hit_tally != '1) hit_tally++;
      res = sacs_pkg::OUT_HIT;
    end else begin
      if (free_way >= 0) begin
        victim = free_way;
        cached_valid[base + victim] = 1'b1;
        res = sacs_pkg::OUT_MISS;
      end else begin
        if (evict_tally != '1) evict_tally++;
        res = sacs_pkg::OUT_EVICT;
      end
      cached_tag[base + victim] = tag;
      cached_age[base + victim] = '0;
      if (miss_tally != '1) miss_tally++;
    end
    return res;
  endfunction

  function automatic bit predict_request(input logic [ADDR_W-1:0] addr, input logic [1:0] act,
                                         output access_result_t r);
    logic [1:0] first, again;
    int i;
    r = '0;
    if (act == sacs_pkg::ACT_INSTR) return 1'b0;
    first = touch_line(addr);
    again = sacs_pkg::OUT_MISS;
    if (act == sacs_pkg::ACT_MODIFY) again = touch_line(addr);
    for (i = 0; i < NUM_LINES; i++)
      if (cached_valid[i] && cached_age[i] != '1) cached_age[i]++;
    r.outcome = first;
    r.second_hit = (act == sacs_pkg::ACT_MODIFY) && (again == sacs_pkg::OUT_HIT);
    r.hits = hit_tally;
    r.misses = miss_tally;
    r.evictions = evict_tally;
    return 1'b1;
  endfunction

  function automatic void set_register(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DAT_W-1:0] data);
    case (idx)
      sacs_pkg::CFG_SET_BITS:   cur_set_bits = data[2:0];
      sacs_pkg::CFG_BLOCK_BITS: cur_block_bits = data;
      sacs_pkg::CFG_WAYS:       cur_ways = data[3:0];
      default: ;
    endcase
  endfunction

  function automatic trace_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DAT_W-1:0] data);
    trace_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.reg_index = idx;
    r.reg_data = data;
    return r;
  endfunction

  function automatic trace_row_t req_row(input logic [ADDR_W-1:0] addr, input logic [1:0] act,
                                         input logic typed, input logic [1:0] oc,
                                         input logic sh, input int h, input int m, input int e);
    trace_row_t r;
    r = '0;
    r.addr = addr;
    r.act = act;
    r.typed = typed;
    r.want.outcome = oc;
    r.want.second_hit = sh;
    r.want.hits = h;
    r.want.misses = m;
    r.want.evictions = e;
    return r;
  endfunction

  function automatic void check_field(input string label, input logic [COUNT_W-1:0] want,
                                      input logic [COUNT_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, label, want, got);
    end
  endfunction

  task automatic send_request(input logic [ADDR_W-1:0] addr, input logic [1:0] act,
                              input logic typed, input access_result_t want);
    access_result_t predicted;
    int gap;
    in_valid <= 1'b1;
    address <= addr;
    action <= act;
    req_held = 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (predict_request(addr, act, predicted))
      pending_results.push_back(typed ? want : predicted);
    gap = burst_mode ? 0 : idle_span();
    if (gap > 0) begin
      in_valid <= 1'b0;
      req_held = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic stop_requests();
    if (req_held) begin
      in_valid <= 1'b0;
      req_held = 1'b0;
    end
  endtask

  // instruction requests produce nothing, so give the pipe time to empty
  task automatic settle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data,
                           input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    set_register(idx, data);
    if (last) cfg_valid <= 1'b0;
  endtask

  task automatic program_cache(input logic [CFG_DAT_W-1:0] sb, input logic [CFG_DAT_W-1:0] bb,
                               input logic [CFG_DAT_W-1:0] wy, input bit spare);
    stop_requests();
    settle();
    write_reg(sacs_pkg::CFG_SET_BITS, sb, 1'b0);
    write_reg(sacs_pkg::CFG_BLOCK_BITS, bb, 1'b0);
    write_reg(sacs_pkg::CFG_WAYS, wy, !spare);
    if (spare) write_reg(CFG_SPARE, CFG_DAT_W'($urandom), 1'b1);
  endtask

  // mostly a small working set of lines, optionally all in one set, plus stray addresses
  task automatic run_phase(input int items);
    logic [ADDR_W-1:0] pool [16];
    logic [ADDR_W-1:0] offset_mask, set_mask, a;
    access_result_t none;
    int pool_n, i, pick;
    bit clash;
    logic [1:0] act;
    none = '0;
    pool_n = $urandom_range(1, 16);
    clash = 1'($urandom_range(0, 1));
    offset_mask = (64'd1 << cur_block_bits) - 64'd1;
    set_mask = ((64'd1 << index_bits()) - 64'd1) << cur_block_bits;
    for (i = 0; i < pool_n; i++) begin
      pool[i] = {$urandom, $urandom};
      if (clash) pool[i] = (pool[i] & ~set_mask) | (pool[0] & set_mask);
    end
    for (i = 0; i < items; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 80)
        a = (pool[$urandom_range(0, pool_n - 1)] & ~offset_mask) |
            ({$urandom, $urandom} & offset_mask);
      else
        a = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      act = (pick < 30) ? ACT_LOAD : (pick < 55) ? ACT_STORE :
            (pick < 85) ? sacs_pkg::ACT_MODIFY : sacs_pkg::ACT_INSTR;
      send_request(a, act, 1'b0, none);
    end
  endtask

  always @(posedge clk) begin
    access_result_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with no request pending, outcome %0d hits %0d",
                 $time, outcome, hit_count);
      end else begin
        want = pending_results.pop_front();
        check_field("outcome", COUNT_W'(want.outcome), COUNT_W'(outcome));
        check_field("second_hit", COUNT_W'(want.second_hit), COUNT_W'(second_hit));
        check_field("hit_count", want.hits, hit_count);
        check_field("miss_count", want.misses, miss_count);
        check_field("evict_count", want.evictions, evict_count);
      end
    end
  end

  initial begin : result_side
    int n;
    while (rst) @(posedge clk);
    forever begin
      if (hold_go && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_done = 1'b1;
        @(posedge clk);
      end else begin
        n = idle_span();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
          out_stall <= 1'b0;
        end
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 4);
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("** set_assoc_lru_cache_sim: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int i, k, ph;
    for (i = 0; i < NUM_LINES; i++) begin
      cached_valid[i] = 1'b0;
      cached_tag[i] = '0;
      cached_age[i] = '0;
    end

    // reset settings: 16 sets of one way, 16-byte blocks
    directed.push_back(req_row(64'h0, ACT_LOAD, 1'b1, sacs_pkg::OUT_MISS, 1'b0, 0, 1, 0));
    directed.push_back(req_row(64'h0, ACT_LOAD, 1'b1, sacs_pkg::OUT_HIT, 1'b0, 1, 1, 0));
    directed.push_back(req_row(64'h100, ACT_STORE, 1'b1, sacs_pkg::OUT_EVICT, 1'b0, 1, 2, 1));
    directed.push_back(req_row(64'h100, sacs_pkg::ACT_MODIFY, 1'b1, sacs_pkg::OUT_HIT, 1'b1,
                               3, 2, 1));
    directed.push_back(req_row('1, sacs_pkg::ACT_INSTR, 1'b0, sacs_pkg::OUT_HIT, 1'b0,
                               0, 0, 0));
    directed.push_back(req_row('1, sacs_pkg::ACT_MODIFY, 1'b1, sacs_pkg::OUT_MISS, 1'b1,
                               4, 3, 1));
    // unmapped register index leaves settings alone
    directed.push_back(cfg_row(CFG_SPARE, 5'h1F));
    directed.push_back(req_row(64'h100, ACT_LOAD, 1'b1, sacs_pkg::OUT_HIT, 1'b0, 5, 3, 1));
    // set bits and ways out of range, old lines kept
    directed.push_back(cfg_row(sacs_pkg::CFG_SET_BITS, 5'h1F));
    directed.push_back(cfg_row(sacs_pkg::CFG_BLOCK_BITS, 5'h00));
    directed.push_back(cfg_row(sacs_pkg::CFG_WAYS, 5'h00));
    directed.push_back(req_row(64'h0, ACT_LOAD, 1'b0, sacs_pkg::OUT_HIT, 1'b0, 0, 0, 0));
    directed.push_back(req_row(64'h40, ACT_LOAD, 1'b0, sacs_pkg::OUT_HIT, 1'b0, 0, 0, 0));
    directed.push_back(req_row(64'h3F, ACT_STORE, 1'b0, sacs_pkg::OUT_HIT, 1'b0, 0, 0, 0));
    directed.push_back(cfg_row(sacs_pkg::CFG_WAYS, 5'h1F));
    directed.push_back(cfg_row(sacs_pkg::CFG_BLOCK_BITS, 5'h1F));
    directed.push_back(cfg_row(sacs_pkg::CFG_SET_BITS, 5'h00));
    // fill all eight ways of one set, then lru eviction
    for (k = 1; k <= 9; k++)
      directed.push_back(req_row(ADDR_W'(k) << 31, ACT_LOAD, 1'b0, sacs_pkg::OUT_HIT, 1'b0,
                                 0, 0, 0));
    directed.push_back(req_row(64'd1 << 31, ACT_LOAD, 1'b0, sacs_pkg::OUT_HIT, 1'b0, 0, 0, 0));
    directed.push_back(req_row({1'b1, 63'd2 << 31}, sacs_pkg::ACT_MODIFY, 1'b0,
                               sacs_pkg::OUT_HIT, 1'b0, 0, 0, 0));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < directed.size(); i++) begin
      if (directed[i].is_cfg) begin
        if (i == 0 || !directed[i - 1].is_cfg) begin
          stop_requests();
          settle();
        end
        write_reg(directed[i].reg_index, directed[i].reg_data,
                  (i + 1 == directed.size()) || !directed[i + 1].is_cfg);
      end else begin
        send_request(directed[i].addr, directed[i].act, directed[i].typed, directed[i].want);
      end
    end

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: program_cache(5'd0, 5'd0, 5'd1, 1'b0);
        1: program_cache(5'd6, 5'd31, 5'd8, 1'b0);
        2: program_cache(5'd7, 5'd3, 5'd15, 1'b1);
        3: program_cache(5'd2, 5'd1, 5'd0, 1'b0);
        default: program_cache(CFG_DAT_W'($urandom), CFG_DAT_W'($urandom),
                               CFG_DAT_W'($urandom), 1'($urandom_range(0, 1)));
      endcase
      burst_mode = (ph == 2) || ($urandom_range(0, 5) == 0);
      if (ph == 2) hold_go = 1'b1;
      run_phase(PHASE_ITEMS);
    end

    stop_requests();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES * 4) @(posedge clk);
    if (errors == 0)
      $display("** set_assoc_lru_cache_sim: PASSED **");
    else
      $display("** set_assoc_lru_cache_sim: FAILED **");
    $finish;
  end

endmodule
